// ----- hdl/scd_pkg.sv -----
// ----------------------------------------------------------------------------
// scd_pkg
// Shared widths, codes and result type for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package scd_pkg;

   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 7;
   localparam int STATUS_W = 2;

   localparam logic [BYTE_W-1:0]   HEADER_BYTE      = 8'hff;
   localparam logic [BYTE_W-1:0]   MIN_FRAME_LENGTH = 8'd6;
   localparam logic [BYTE_W-1:0]   MAX_FRAME_LENGTH = 8'd128;
   localparam logic [OFFSET_W-1:0] LAST_OFFSET      = 7'd127;

   localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_LENGTH   = 2'd2;

   typedef struct packed {
      logic [OFFSET_W-1:0] frame_offset;
      logic [BYTE_W-1:0]   frame_byte;
      logic                frame_last;
      logic [STATUS_W-1:0] frame_status;
   } rsp_type;

endpackage

// ----- hdl/scd_in_reg.sv -----
// ----------------------------------------------------------------------------
// scd_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module scd_in_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [scd_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                       consume,
   output logic                       in_valid,
   output logic [scd_pkg::BYTE_W-1:0] in_byte
);
   import scd_pkg::*;

   logic              vld_ff, vld_in;
   logic [BYTE_W-1:0] byte_ff;

   assign req_ready = !vld_ff || consume;
   assign vld_in    = (req_valid && req_ready) || (vld_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign in_valid = vld_ff;
   assign in_byte  = byte_ff;

endmodule

// ----- hdl/scd_core.sv -----
// ----------------------------------------------------------------------------
// scd_core
// Header hunt, length capture and checksum check, one byte per cycle while results are taken.
// ----------------------------------------------------------------------------
module scd_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic                       csr_write_data,
   input  logic                       in_valid,
   input  logic [scd_pkg::BYTE_W-1:0] in_byte,
   input  logic                       out_can_take,
   output logic                       consume,
   output logic                       push,
   output scd_pkg::rsp_type           rsp
);
   import scd_pkg::*;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_FRAME  = 2'd2;

   logic                lenpos_ff;
   logic [1:0]          phase_ff, phase_in;
   logic [OFFSET_W-1:0] pos_ff, pos_in;
   logic [BYTE_W-1:0]   len_ff, len_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;

   logic                has_rsp;
   logic [OFFSET_W-1:0] cap_at;
   logic [BYTE_W-1:0]   len_eff;
   logic                len_bad;

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      has_rsp  = 1'b0;
      rsp      = '{frame_offset: pos_ff, frame_byte: in_byte,
                   frame_last: 1'b0, frame_status: STATUS_GOOD};
      cap_at   = lenpos_ff ? 7'd2 : 7'd3;
      len_eff  = len_ff;
      len_bad  = 1'b0;
      case (phase_ff)
         PHASE_SECOND: begin
            if (in_byte == HEADER_BYTE) begin
               phase_in = PHASE_FRAME;
               pos_in   = 7'd2;
               len_in   = '0;
               sum_in   = '0;
            end else begin
               phase_in = PHASE_FIRST;
            end
         end
         PHASE_FRAME: begin
            has_rsp = 1'b1;
            if (len_ff == '0 && pos_ff == cap_at) begin
               if (in_byte < MIN_FRAME_LENGTH || in_byte > MAX_FRAME_LENGTH) begin
                  len_bad = 1'b1;
               end else begin
                  len_eff = in_byte;
               end
            end
            if (len_bad) begin
               rsp.frame_last   = 1'b1;
               rsp.frame_status = STATUS_LENGTH;
            end else if (len_eff != '0 && {1'b0, pos_ff} == len_eff - 8'd1) begin
               rsp.frame_last   = 1'b1;
               rsp.frame_status = (in_byte == ~sum_ff) ? STATUS_GOOD : STATUS_CHECKSUM;
            end else if (pos_ff == LAST_OFFSET) begin
               // no length seen by the last offset: give up on the frame
               rsp.frame_last   = 1'b1;
               rsp.frame_status = STATUS_LENGTH;
            end else begin
               sum_in = sum_ff + in_byte;
               pos_in = pos_ff + 7'd1;
               len_in = len_eff;
            end
            if (rsp.frame_last) begin
               phase_in = PHASE_FIRST;
               pos_in   = '0;
               len_in   = '0;
               sum_in   = '0;
            end
         end
         default: begin
            phase_in = (in_byte == HEADER_BYTE) ? PHASE_SECOND : PHASE_FIRST;
         end
      endcase
   end

   // stall only when a result has nowhere to go
   assign consume = in_valid && (!has_rsp || out_can_take);
   assign push    = consume && has_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         lenpos_ff <= 1'b0;
         phase_ff  <= PHASE_FIRST;
         pos_ff    <= '0;
         len_ff    <= '0;
         sum_ff    <= '0;
      end else begin
         if (csr_write_en) begin
            lenpos_ff <= csr_write_data;
         end
         if (consume) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            len_ff   <= len_in;
            sum_ff   <= sum_in;
         end
      end
   end

endmodule

// ----- hdl/scd_out_reg.sv -----
// ----------------------------------------------------------------------------
// scd_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module scd_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  scd_pkg::rsp_type rsp,
   output logic             out_can_take,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output scd_pkg::rsp_type rsp_data
);
   import scd_pkg::*;

   logic    vld_ff, vld_in;
   rsp_type data_ff;

   assign out_can_take = !vld_ff || rsp_ready;
   assign vld_in       = push || (vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= rsp;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- hdl/sync_length_checksum_deframer.sv -----
// A request is held in the input register, then its result in the result register.
// Throughput: one byte per cycle while results are taken; header and hunt
// bytes give no result and never stall. With a result held in the result
// register, one more frame byte waits in the input register and the input then stalls.
// Reset (synchronous): back to hunting for the header, length position 0,
// both registers empty.
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Byte-serial frame parser: header hunt, length check and inverted-sum check.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic                         csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [scd_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [scd_pkg::OFFSET_W-1:0] rsp_frame_offset,
   output logic [scd_pkg::BYTE_W-1:0]   rsp_frame_byte,
   output logic                         rsp_frame_last,
   output logic [scd_pkg::STATUS_W-1:0] rsp_frame_status
);
   import scd_pkg::*;

   logic              in_valid, consume, push, out_can_take;
   logic [BYTE_W-1:0] in_byte;
   rsp_type           rsp, rsp_data;

   scd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .consume     (consume),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   scd_core u_core (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .in_valid       (in_valid),
      .in_byte        (in_byte),
      .out_can_take   (out_can_take),
      .consume        (consume),
      .push           (push),
      .rsp            (rsp)
   );

   scd_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .rsp          (rsp),
      .out_can_take (out_can_take),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   assign rsp_frame_offset = rsp_data.frame_offset;
   assign rsp_frame_byte   = rsp_data.frame_byte;
   assign rsp_frame_last   = rsp_data.frame_last;
   assign rsp_frame_status = rsp_data.frame_status;

   a_status_on_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_last |-> rsp_frame_status == STATUS_GOOD)
      else $error("status set on a non-last byte");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_status == STATUS_GOOD ||
                    rsp_frame_status == STATUS_CHECKSUM ||
                    rsp_frame_status == STATUS_LENGTH)
      else $error("unknown frame status");

   a_offset_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_offset >= 7'd2)
      else $error("header offset emitted");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      push |-> out_can_take)
      else $error("result pushed into a full register");

endmodule

// ----- tb/sync_length_checksum_deframer_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sync_length_checksum_deframer_tb
// Feeds header hunts, good frames, corrupt frames and line noise into the
// deframer. Both handshakes get random gaps. Every emitted frame byte is
// predicted and compared field by field. The length position changes between
// bursts, and a burst may stop inside a frame.
// ---------------------------------------------------------------------------
module sync_length_checksum_deframer_tb;
   import scd_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 4;
   localparam int ITEM_TARGET   = 1700;
   localparam int GAP_MAX       = 18;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 8;
   localparam int CYCLE_LIMIT   = 500000;

   localparam logic [OFFSET_W-1:0] FIRST_FRAME_OFFSET  = 7'd2;
   localparam logic [OFFSET_W-1:0] LEN_OFFSET_INSTR    = 7'd3;
   localparam logic [OFFSET_W-1:0] LEN_OFFSET_FEEDBACK = 7'd2;
   localparam bit LENPOS_INSTR    = 1'b0;
   localparam bit LENPOS_FEEDBACK = 1'b1;

   typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, IN_FRAME} hunt_state_type;
   typedef logic [BYTE_W-1:0] byte_q_type[$];

   // Tracks the parser state and holds the frame bytes still owed by the block.
   class deframe_scoreboard;
      bit                  len_at_feedback;
      hunt_state_type      state;
      logic [OFFSET_W-1:0] next_offset;
      logic [BYTE_W-1:0]   captured_len;
      logic [BYTE_W-1:0]   checksum_acc;
      rsp_type             pending_frame_bytes[$];
      int errors, predicted, checked, good_frames, checksum_frames, length_frames;

      function new();
         len_at_feedback = LENPOS_INSTR;
         restart_hunt();
         errors          = 0;
         predicted       = 0;
         checked         = 0;
         good_frames     = 0;
         checksum_frames = 0;
         length_frames   = 0;
      endfunction

      function void restart_hunt();
         state        = HUNT_FIRST;
         next_offset  = '0;
         captured_len = '0;
         checksum_acc = '0;
      endfunction

      function void note_rx_byte(logic [BYTE_W-1:0] b);
         logic [OFFSET_W-1:0] pos;
         logic [OFFSET_W-1:0] len_offset;
         logic [BYTE_W-1:0]   wanted_sum;
         rsp_type             r;
         bit                  closing;
         if (state == HUNT_SECOND) begin
            if (b == HEADER_BYTE) begin
               state        = IN_FRAME;
               next_offset  = FIRST_FRAME_OFFSET;
               captured_len = '0;
               checksum_acc = '0;
            end else begin
               state = HUNT_FIRST;
            end
            return;
         end
         if (state != IN_FRAME) begin
            if (b == HEADER_BYTE) begin
               state = HUNT_SECOND;
            end else begin
               state = HUNT_FIRST;
            end
            return;
         end

         pos        = next_offset;
         len_offset = len_at_feedback ? LEN_OFFSET_FEEDBACK : LEN_OFFSET_INSTR;
         wanted_sum = ~checksum_acc;
         closing    = 1'b0;
         r.frame_offset = pos;
         r.frame_byte   = b;
         r.frame_last   = 1'b1;
         r.frame_status = STATUS_GOOD;

         // capture the length once, at whatever offset is selected right now
         if (captured_len == '0 && pos == len_offset) begin
            if (b < MIN_FRAME_LENGTH || b > MAX_FRAME_LENGTH) begin
               r.frame_status = STATUS_LENGTH;
               closing        = 1'b1;
            end else begin
               captured_len = b;
            end
         end
         if (!closing && captured_len != '0 && {1'b0, pos} == captured_len - 8'd1) begin
            closing = 1'b1;
            if (b != wanted_sum) begin
               r.frame_status = STATUS_CHECKSUM;
            end
         end
         // length never captured: run out at the last offset
         if (!closing && pos == LAST_OFFSET) begin
            closing        = 1'b1;
            r.frame_status = STATUS_LENGTH;
         end

         if (closing) begin
            restart_hunt();
         end else begin
            checksum_acc = checksum_acc + b;
            next_offset  = pos + 7'd1;
            r.frame_last = 1'b0;
         end
         pending_frame_bytes.push_back(r);
         predicted++;
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_frame_bytes.size() == 0) begin
            $display("%0t: result with nothing expected, actual offset %0d byte %0h",
                     $time, got.frame_offset, got.frame_byte);
            $display("%0t:    last %0b status %0d", $time, got.frame_last, got.frame_status);
            errors++;
            return;
         end
         want = pending_frame_bytes.pop_front();
         checked++;
         compare_field("frame_offset", 32'(want.frame_offset), 32'(got.frame_offset));
         compare_field("frame_byte", 32'(want.frame_byte), 32'(got.frame_byte));
         compare_field("frame_last", 32'(want.frame_last), 32'(got.frame_last));
         compare_field("frame_status", 32'(want.frame_status), 32'(got.frame_status));
         if (want.frame_last) begin
            case (want.frame_status)
               STATUS_GOOD:     good_frames++;
               STATUS_CHECKSUM: checksum_frames++;
               default:         length_frames++;
            endcase
         end
      endfunction
   endclass

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                csr_write_en   = 1'b0;
   logic                csr_write_data = 1'b0;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_rx_byte    = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [OFFSET_W-1:0] rsp_frame_offset;
   logic [BYTE_W-1:0]   rsp_frame_byte;
   logic                rsp_frame_last;
   logic [STATUS_W-1:0] rsp_frame_status;

   deframe_scoreboard sb;
   int  cycle_count = 0;
   int  csr_writes  = 0;
   int  bursts      = 0;
   int  bytes_sent  = 0;
   bit  req_calm    = 1'b0;
   bit  rsp_calm    = 1'b0;

   sync_length_checksum_deframer u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_offset (rsp_frame_offset),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_frame_status (rsp_frame_status)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
         $display("** sync_length_checksum_deframer: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_rx_byte(req_rx_byte);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_response({rsp_frame_offset, rsp_frame_byte, rsp_frame_last,
                               rsp_frame_status});
         end
      end
   end

   function automatic int draw_gap(bit calm);
      if (calm) begin
         return 0;
      end
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, GAP_MAX) : $urandom_range(0, 2);
   endfunction

   function automatic logic [BYTE_W-1:0] random_byte();
      return ($urandom_range(0, 7) == 0) ? HEADER_BYTE : 8'($urandom_range(0, 255));
   endfunction

   // result side: stall a random number of cycles before taking each result
   initial begin : result_sink
      int stall;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 40) == 0) begin
            rsp_calm = !rsp_calm;
         end
         stall = draw_gap(rsp_calm);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_bytes(input byte_q_type stream);
      int gap;
      foreach (stream[i]) begin
         if ($urandom_range(0, 40) == 0) begin
            req_calm = !req_calm;
         end
         gap = draw_gap(req_calm);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_rx_byte <= stream[i];
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_until_drained(input int settle);
      do @(posedge clock); while (sb.pending_frame_bytes.size() != 0);
      // let a trailing header or noise byte clear the pipeline
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_length_position(input bit feedback);
      wait_until_drained(SETTLE_CYCLES);
      csr_write_en   <= 1'b1;
      csr_write_data <= feedback;
      @(posedge clock);
      csr_write_en       <= 1'b0;
      sb.len_at_feedback = feedback;
      csr_writes++;
   endtask

   // One frame, a length error, a bad checksum, a truncated frame or noise.
   task automatic build_frame(input bit feedback, output byte_q_type q);
      int kind, len, len_off, end_off, off, pick;
      logic [BYTE_W-1:0] sum, b;
      q = {};
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 5)) q.push_back(random_byte());
         return;
      end
      q.push_back(HEADER_BYTE);
      q.push_back(HEADER_BYTE);
      len_off = feedback ? int'(LEN_OFFSET_FEEDBACK) : int'(LEN_OFFSET_INSTR);
      if (kind < 18) begin
         len = $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(129, 255);
      end else begin
         // keep most frames short
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = $urandom_range(6, 16);
         end else if (pick < 90) begin
            len = $urandom_range(17, 60);
         end else if (pick < 96) begin
            len = $urandom_range(61, 127);
         end else begin
            len = int'(MAX_FRAME_LENGTH);
         end
      end
      if (kind < 18) begin
         end_off = len_off + 1;
      end else if (kind >= 30 && kind < 38) begin
         end_off = $urandom_range(3, len - 1);
      end else begin
         end_off = len;
      end
      sum = '0;
      for (off = int'(FIRST_FRAME_OFFSET); off < end_off; off++) begin
         if (off == len_off) begin
            b = 8'(len);
         end else if (off == len - 1) begin
            b = ~sum ^ ((kind < 30) ? 8'($urandom_range(1, 255)) : 8'h00);
         end else begin
            b = random_byte();
         end
         sum = sum + b;
         q.push_back(b);
      end
   endtask

   initial begin : stimulus
      byte_q_type stream, frame_q;
      int         target;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      set_length_position(LENPOS_INSTR);
      // noise, lone header byte, third header byte as frame data, shortest good
      // frame, length below and above the allowed range
      stream = {8'h00, HEADER_BYTE, 8'h7e,
                HEADER_BYTE, HEADER_BYTE, HEADER_BYTE, 8'h06, 8'h00, 8'hfa,
                HEADER_BYTE, HEADER_BYTE, 8'h01, 8'h05,
                HEADER_BYTE, HEADER_BYTE, 8'h02, 8'h81};
      send_bytes(stream);
      bytes_sent += stream.size();
      set_length_position(LENPOS_FEEDBACK);
      // feedback frame with a checksum off by one
      stream = {HEADER_BYTE, HEADER_BYTE, 8'h06, 8'h12, 8'h34, 8'hb2};
      send_bytes(stream);
      bytes_sent += stream.size();

      // bursts end anywhere, so some length-position writes land mid-frame
      while (bytes_sent < ITEM_TARGET) begin
         set_length_position(1'($urandom_range(0, 1)));
         target = $urandom_range(60, 300);
         stream = {};
         while (stream.size() < target) begin
            build_frame(sb.len_at_feedback, frame_q);
            foreach (frame_q[i]) begin
               if (stream.size() < target) begin
                  stream.push_back(frame_q[i]);
               end
            end
         end
         send_bytes(stream);
         bytes_sent += stream.size();
         bursts++;
      end

      wait_until_drained(END_CYCLES);
      $display("Sent %0d bytes in %0d random bursts, checked %0d of %0d predicted frame bytes",
               bytes_sent, bursts, sb.checked, sb.predicted);
      $display("Frame endings: %0d good, %0d checksum, %0d length; %0d length-position writes",
               sb.good_frames, sb.checksum_frames, sb.length_frames, csr_writes);
      if (sb.errors == 0) begin
         $display("** sync_length_checksum_deframer: PASSED **");
      end else begin
         $display("** sync_length_checksum_deframer: FAILED **");
      end
      $finish;
   end

endmodule
